// ----- design/ufr_pkg.sv -----
// ----------------------------------------------------------------------------
// ufr_pkg: shared types and constants for the update frame receiver
// Phase and session state encodings, event codes, register indexes and
// the control bundle passed from the frame parser to the session tracker.
// ----------------------------------------------------------------------------
package ufr_pkg;

    localparam int MAX_PAYLOAD_DEF = 1024;
    localparam int CRC_BYTES       = 4;

    // Configuration register indexes
    localparam logic [2:0] REG_START_BYTE   = 3'd0;
    localparam logic [2:0] REG_END_BYTE     = 3'd1;
    localparam logic [2:0] REG_TYPE_COMMAND = 3'd2;
    localparam logic [2:0] REG_TYPE_PAYLOAD = 3'd3;
    localparam logic [2:0] REG_TYPE_HEADER  = 3'd4;
    localparam logic [2:0] REG_CODE_BEGIN   = 3'd5;
    localparam logic [2:0] REG_CODE_FINISH  = 3'd6;

    // Register reset values
    localparam logic [7:0] RST_START_BYTE   = 8'd170;
    localparam logic [7:0] RST_END_BYTE     = 8'd187;
    localparam logic [7:0] RST_TYPE_COMMAND = 8'd0;
    localparam logic [7:0] RST_TYPE_PAYLOAD = 8'd1;
    localparam logic [7:0] RST_TYPE_HEADER  = 8'd2;
    localparam logic [7:0] RST_CODE_BEGIN   = 8'd0;
    localparam logic [7:0] RST_CODE_FINISH  = 8'd1;

    // Reported phase codes
    localparam logic [2:0] PH_CODE_HUNT = 3'd0;
    localparam logic [2:0] PH_CODE_TYPE = 3'd1;
    localparam logic [2:0] PH_CODE_LEN  = 3'd2;
    localparam logic [2:0] PH_CODE_DATA = 3'd3;
    localparam logic [2:0] PH_CODE_CRC  = 3'd4;
    localparam logic [2:0] PH_CODE_END  = 3'd5;

    // Reported session codes
    localparam logic [1:0] SS_CODE_IDLE   = 2'd0;
    localparam logic [1:0] SS_CODE_HEADER = 2'd1;
    localparam logic [1:0] SS_CODE_DATA   = 2'd2;
    localparam logic [1:0] SS_CODE_END    = 2'd3;

    // Session events
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_START  = 3'd1;
    localparam logic [2:0] EV_HEADER = 3'd2;
    localparam logic [2:0] EV_CHUNK  = 3'd3;
    localparam logic [2:0] EV_FINISH = 3'd4;
    localparam logic [2:0] EV_ABORT  = 3'd5;

    typedef enum logic [5:0] {
        PH_HUNT = 6'b000001,
        PH_TYPE = 6'b000010,
        PH_LEN  = 6'b000100,
        PH_DATA = 6'b001000,
        PH_CRC  = 6'b010000,
        PH_END  = 6'b100000
    } phase_t;

    typedef enum logic [3:0] {
        SS_IDLE   = 4'b0001,
        SS_HEADER = 4'b0010,
        SS_DATA   = 4'b0100,
        SS_END    = 4'b1000
    } session_t;

    // Parser -> session tracker bundle
    typedef struct packed {
        logic        restart;
        logic        done;
        logic [7:0]  ftype;
        logic [31:0] lead;
        logic [15:0] flen;
    } frame_evt_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_HUNT: code = PH_CODE_HUNT;
            PH_TYPE: code = PH_CODE_TYPE;
            PH_LEN:  code = PH_CODE_LEN;
            PH_DATA: code = PH_CODE_DATA;
            PH_CRC:  code = PH_CODE_CRC;
            PH_END:  code = PH_CODE_END;
            default: code = PH_CODE_HUNT;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] session_code(input session_t ss);
        logic [1:0] code;
        unique case (ss)
            SS_IDLE:   code = SS_CODE_IDLE;
            SS_HEADER: code = SS_CODE_HEADER;
            SS_DATA:   code = SS_CODE_DATA;
            SS_END:    code = SS_CODE_END;
            default:   code = SS_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- design/ufr_frame_parser.sv -----
// ----------------------------------------------------------------------------
// ufr_frame_parser: byte-level frame framing
// Hunts for the start byte, then walks type, length, payload, CRC and end
// byte. Streams payload bytes and flags a completed or dropped frame.
// ----------------------------------------------------------------------------
module ufr_frame_parser #(
    parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                restart,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          start_byte,
    input  logic [7:0]          end_byte,
    output logic [2:0]          phase_out,
    output logic [7:0]          payload_byte,
    output logic                payload_strobe,
    output logic                frame_dropped,
    output ufr_pkg::frame_evt_t evt
);

    localparam int          POS_W   = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    ufr_pkg::phase_t phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] pos_inc;
    logic [15:0]      len_reg, len_next;
    logic [7:0]       type_reg, type_next;
    logic [31:0]      lead_reg, lead_next;
    logic             done;

    assign pos_inc = pos_reg + POS_W'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        type_next      = type_reg;
        lead_next      = lead_reg;
        payload_byte   = 8'h00;
        payload_strobe = 1'b0;
        frame_dropped  = 1'b0;
        done           = 1'b0;
        if (restart)
        begin
            phase_next = ufr_pkg::PH_HUNT;
            pos_next   = '0;
            len_next   = '0;
            type_next  = '0;
            lead_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                ufr_pkg::PH_HUNT:
                begin
                    if (rx_byte == start_byte)
                    begin
                        pos_next   = '0;
                        len_next   = '0;
                        type_next  = '0;
                        lead_next  = '0;
                        phase_next = ufr_pkg::PH_TYPE;
                    end
                end
                ufr_pkg::PH_TYPE:
                begin
                    type_next  = rx_byte;
                    pos_next   = '0;
                    phase_next = ufr_pkg::PH_LEN;
                end
                ufr_pkg::PH_LEN:
                begin
                    if (pos_reg == '0)
                    begin
                        len_next = {8'h00, rx_byte};
                        pos_next = POS_W'(1);
                    end
                    else
                    begin
                        len_next = {rx_byte, len_reg[7:0]};
                        pos_next = '0;
                        if ({1'b0, len_next} > MAX_LEN)
                        begin
                            frame_dropped = 1'b1;
                            phase_next    = ufr_pkg::PH_HUNT;
                        end
                        else if (len_next == 16'h0000)
                            phase_next = ufr_pkg::PH_CRC;
                        else
                            phase_next = ufr_pkg::PH_DATA;
                    end
                end
                ufr_pkg::PH_DATA:
                begin
                    payload_byte   = rx_byte;
                    payload_strobe = 1'b1;
                    // first four payload bytes kept little endian
                    if (pos_reg < POS_W'(4))
                        lead_next[{pos_reg[1:0], 3'b000} +: 8] = rx_byte;
                    if (16'(pos_inc) >= len_reg)
                    begin
                        pos_next   = '0;
                        phase_next = ufr_pkg::PH_CRC;
                    end
                    else
                        pos_next = pos_inc;
                end
                ufr_pkg::PH_CRC:
                begin
                    if (pos_inc >= POS_W'(ufr_pkg::CRC_BYTES))
                    begin
                        pos_next   = '0;
                        phase_next = ufr_pkg::PH_END;
                    end
                    else
                        pos_next = pos_inc;
                end
                ufr_pkg::PH_END:
                begin
                    if (rx_byte == end_byte)
                        done = 1'b1;
                    else
                        frame_dropped = 1'b1;
                    pos_next   = '0;
                    phase_next = ufr_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = ufr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    assign phase_out   = ufr_pkg::phase_code(phase_next);
    assign evt.restart = restart;
    assign evt.done    = done;
    assign evt.ftype   = type_reg;
    assign evt.lead    = lead_reg;
    assign evt.flen    = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ufr_pkg::PH_HUNT;
            pos_reg   <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            lead_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            lead_reg  <= lead_next;
        end
    end

endmodule

// ----- design/ufr_session.sv -----
// ----------------------------------------------------------------------------
// ufr_session: update session tracker
// Steps begin / header / data chunks / finish on each completed frame and
// keeps the file size and the running write offset.
// ----------------------------------------------------------------------------
module ufr_session (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ufr_pkg::frame_evt_t evt,
    input  logic [7:0]          type_command,
    input  logic [7:0]          type_payload,
    input  logic [7:0]          type_header,
    input  logic [7:0]          code_begin,
    input  logic [7:0]          code_finish,
    output logic [1:0]          session_state,
    output logic [2:0]          session_event,
    output logic [31:0]         chunk_offset,
    output logic [10:0]         chunk_length,
    output logic [31:0]         file_size
);

    ufr_pkg::session_t sess_reg, sess_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] bw_reg, bw_next;
    logic        is_cmd;
    logic [7:0]  code;

    assign is_cmd = (evt.ftype == type_command);
    assign code   = evt.lead[7:0];

    always_comb
    begin
        sess_next     = sess_reg;
        exp_next      = exp_reg;
        bw_next       = bw_reg;
        session_event = ufr_pkg::EV_NONE;
        chunk_offset  = '0;
        chunk_length  = '0;
        if (evt.restart)
        begin
            sess_next = ufr_pkg::SS_IDLE;
            exp_next  = '0;
            bw_next   = '0;
        end
        else if (evt.done)
        begin
            unique case (sess_reg)
                ufr_pkg::SS_IDLE:
                begin
                    if (is_cmd)
                    begin
                        if (code == code_begin)
                        begin
                            sess_next     = ufr_pkg::SS_HEADER;
                            session_event = ufr_pkg::EV_START;
                        end
                    end
                    else
                    begin
                        exp_next = '0;
                        bw_next  = '0;
                    end
                end
                ufr_pkg::SS_HEADER:
                begin
                    if (evt.ftype == type_header)
                    begin
                        exp_next      = evt.lead;
                        sess_next     = ufr_pkg::SS_DATA;
                        session_event = ufr_pkg::EV_HEADER;
                    end
                    else
                    begin
                        sess_next     = ufr_pkg::SS_IDLE;
                        exp_next      = '0;
                        bw_next       = '0;
                        session_event = ufr_pkg::EV_ABORT;
                    end
                end
                ufr_pkg::SS_DATA:
                begin
                    if (evt.ftype == type_payload)
                    begin
                        chunk_offset  = bw_reg;
                        chunk_length  = evt.flen[10:0];
                        bw_next       = bw_reg + 32'(evt.flen);
                        session_event = ufr_pkg::EV_CHUNK;
                        if (bw_next >= exp_reg)
                            sess_next = ufr_pkg::SS_END;
                    end
                end
                ufr_pkg::SS_END:
                begin
                    if (is_cmd)
                    begin
                        if (code == code_finish)
                        begin
                            sess_next     = ufr_pkg::SS_IDLE;
                            exp_next      = '0;
                            bw_next       = '0;
                            session_event = ufr_pkg::EV_FINISH;
                        end
                    end
                    else
                    begin
                        sess_next     = ufr_pkg::SS_IDLE;
                        exp_next      = '0;
                        bw_next       = '0;
                        session_event = ufr_pkg::EV_ABORT;
                    end
                end
                default:
                begin
                    sess_next = ufr_pkg::SS_IDLE;
                end
            endcase
        end
    end

    assign session_state = ufr_pkg::session_code(sess_next);
    assign file_size     = exp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_reg <= ufr_pkg::SS_IDLE;
            exp_reg  <= '0;
            bw_reg   <= '0;
        end
        else if (step)
        begin
            sess_reg <= sess_next;
            exp_reg  <= exp_next;
            bw_reg   <= bw_next;
        end
    end

endmodule

// ----- design/update_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// update_frame_receiver: framed firmware-update byte receiver
// Parses start/type/length/payload/CRC/end frames from a byte stream and
// steps an update session on every good frame.
// ----------------------------------------------------------------------------
//
// Channel    Dir  Handshake                Content
// s_axis     in   tvalid/tready            tdata: rx_byte, tuser: command
// m_axis     out  tvalid/tready            tdata: one status beat per input beat
// cfg        in   cfg_we (no handshake)    cfg_addr selects, cfg_data written
//
// The parser and session logic sit between the state registers and the output
// register; one beat per clock while m_axis_tready keeps the output draining.
// An input beat is taken whenever the output register is empty or is being
// drained in the same cycle, so full throughput needs m_axis_tready held high.
// Reset (rst_n low, async) puts the parser in hunt, the session in idle,
// clears the counters and loads the register defaults.
// The CRC bytes are counted and skipped; they are not checked.
//
module update_frame_receiver #(
    parameter int MAX_PAYLOAD = ufr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] command (1 = restart)
    // result beats
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] frame_phase, [4:3] session_state, [12:5] payload_byte,
    // [13] payload_strobe, [14] frame_done, [15] frame_dropped,
    // [18:16] session_event, [50:19] chunk_offset, [61:51] chunk_length,
    // [93:62] file_size, [95:94] zero
    output logic [95:0] m_axis_tdata,
    // configuration writes
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] type_command_reg;
    logic [7:0] type_payload_reg;
    logic [7:0] type_header_reg;
    logic [7:0] code_begin_reg;
    logic [7:0] code_finish_reg;

    logic        step;
    logic [2:0]  frame_phase;
    logic [7:0]  payload_byte;
    logic        payload_strobe;
    logic        frame_dropped;
    logic [1:0]  session_state;
    logic [2:0]  session_event;
    logic [31:0] chunk_offset;
    logic [10:0] chunk_length;
    logic [31:0] file_size;
    ufr_pkg::frame_evt_t evt;

    logic        out_valid_reg;
    logic [95:0] out_data_reg;

    // Output register is empty or drains this cycle -> room for a new beat
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= ufr_pkg::RST_START_BYTE;
            end_byte_reg     <= ufr_pkg::RST_END_BYTE;
            type_command_reg <= ufr_pkg::RST_TYPE_COMMAND;
            type_payload_reg <= ufr_pkg::RST_TYPE_PAYLOAD;
            type_header_reg  <= ufr_pkg::RST_TYPE_HEADER;
            code_begin_reg   <= ufr_pkg::RST_CODE_BEGIN;
            code_finish_reg  <= ufr_pkg::RST_CODE_FINISH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ufr_pkg::REG_START_BYTE:   start_byte_reg   <= cfg_data;
                ufr_pkg::REG_END_BYTE:     end_byte_reg     <= cfg_data;
                ufr_pkg::REG_TYPE_COMMAND: type_command_reg <= cfg_data;
                ufr_pkg::REG_TYPE_PAYLOAD: type_payload_reg <= cfg_data;
                ufr_pkg::REG_TYPE_HEADER:  type_header_reg  <= cfg_data;
                ufr_pkg::REG_CODE_BEGIN:   code_begin_reg   <= cfg_data;
                ufr_pkg::REG_CODE_FINISH:  code_finish_reg  <= cfg_data;
                default:                   ; // unmapped index, write dropped
            endcase
        end
    end

    ufr_frame_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .restart        (s_axis_tuser),
        .rx_byte        (s_axis_tdata),
        .start_byte     (start_byte_reg),
        .end_byte       (end_byte_reg),
        .phase_out      (frame_phase),
        .payload_byte   (payload_byte),
        .payload_strobe (payload_strobe),
        .frame_dropped  (frame_dropped),
        .evt            (evt)
    );

    ufr_session u_session (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .evt           (evt),
        .type_command  (type_command_reg),
        .type_payload  (type_payload_reg),
        .type_header   (type_header_reg),
        .code_begin    (code_begin_reg),
        .code_finish   (code_finish_reg),
        .session_state (session_state),
        .session_event (session_event),
        .chunk_offset  (chunk_offset),
        .chunk_length  (chunk_length),
        .file_size     (file_size)
    );

    // Output register: valid cleared under reset, payload loaded on each taken beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= {2'b00, file_size, chunk_length, chunk_offset,
                             session_event, frame_dropped, evt.done,
                             payload_strobe, payload_byte, session_state,
                             frame_phase};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
